[sv/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg
// Types and constants shared by the loss probe session table and its cells.
// ----------------------------------------------------------------------------
package lps_pkg;

	// index field wide enough for the largest supported table (1024 entries)
	localparam int IDX_W = 10;
	localparam int KEY_W = 64;
	localparam int CNT_W = 16;
	localparam int AGE_W = 7;
	localparam int VER_W = 16;
	localparam int LEN_W = 11;

	localparam logic [AGE_W-1:0] AGE_MAX     = 7'd127;
	localparam logic [LEN_W-1:0] MIN_PKT_LEN = 11'd2;

	localparam logic [VER_W-1:0] EXPVER_RESET   = 16'd0;
	localparam logic [LEN_W-1:0] BASELEN_RESET  = 11'd16;
	localparam logic [AGE_W-1:0] LIFETIME_RESET = 7'd60;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPVER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASELEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd2;

	localparam logic FUNC_PACKET = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	typedef enum logic [1:0] {
		REQ_INIT  = 2'd0,
		REQ_PING  = 2'd1,
		REQ_CLEAN = 2'd2,
		REQ_OTHER = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		RPL_INITIATED = 3'd0,
		RPL_PONG      = 3'd1,
		RPL_PONG_WHO  = 3'd2,
		RPL_CLEANED   = 3'd3,
		RPL_UNKNOWN   = 3'd4
	} reply_kind_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_TICK,
		CMD_INIT,
		CMD_PING,
		CMD_CLEAR
	} cmd_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	// lookup token that walks the cell chain
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [CNT_W-1:0] cnt;
		logic             free;
		logic [IDX_W-1:0] free_idx;
	} token_t;

	// update broadcast to every cell
	typedef struct packed {
		cmd_op_t          op;
		logic [IDX_W-1:0] idx;
	} cell_cmd_t;

endpackage

[sv/lps_cell.sv]
// ----------------------------------------------------------------------------
// lps_cell
// One session entry: holds key, ping count and age, folds its own state into
// the lookup token and passes the token on to the next cell.
// ----------------------------------------------------------------------------
module lps_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [lps_pkg::KEY_W-1:0] id,
	input  logic [lps_pkg::AGE_W-1:0] lifetime,
	input  lps_pkg::cell_cmd_t        cmd,
	input  lps_pkg::token_t           tok_i,
	output lps_pkg::token_t           tok_o
);
	import lps_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q;
	logic [AGE_W-1:0] age_q;
	token_t           tok_q;
	token_t           tok_n;
	logic             sel;
	logic             match;
	logic [AGE_W-1:0] age_inc;

	assign sel     = (cmd.idx == IDX_W'(CELL_IDX));
	assign match   = valid_q && (key_q == id);
	assign age_inc = (age_q < AGE_MAX) ? age_q + 1'b1 : age_q;

	always_comb begin
		tok_n = tok_i;
		if (!tok_i.hit && match) begin
			tok_n.hit     = 1'b1;
			tok_n.hit_idx = IDX_W'(CELL_IDX);
			tok_n.cnt     = count_q + 1'b1;
		end
		if (!tok_i.free && !valid_q) begin
			tok_n.free     = 1'b1;
			tok_n.free_idx = IDX_W'(CELL_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_n;
			case (cmd.op)
				CMD_TICK: begin
					if (valid_q && age_inc >= lifetime) begin
						valid_q <= 1'b0;
					end
				end
				CMD_INIT: begin
					if (sel) begin
						valid_q <= 1'b1;
					end
				end
				CMD_CLEAR: begin
					if (sel) begin
						valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_TICK: begin
				if (valid_q) begin
					age_q <= age_inc;
				end
			end
			CMD_INIT: begin
				if (sel) begin
					key_q   <= id;
					count_q <= '0;
					age_q   <= '0;
				end
			end
			CMD_PING: begin
				if (sel) begin
					count_q <= count_q + 1'b1;
					age_q   <= '0;
				end
			end
			default: ;
		endcase
	end

	assign tok_o = tok_q;

endmodule

[sv/lps_ctrl.sv]
// ----------------------------------------------------------------------------
// lps_ctrl
// Configuration registers, packet screening, search sequencing and reply
// generation for the session table.
// ----------------------------------------------------------------------------
module lps_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [lps_pkg::LEN_W-1:0]      pkt_length,
	input  logic [lps_pkg::VER_W-1:0]      pkt_version,
	input  logic [1:0]                     request_kind,
	input  logic [lps_pkg::KEY_W-1:0]      session_id,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           done,
	output logic [2:0]                     reply_kind,
	output logic [lps_pkg::VER_W-1:0]      reply_version,
	output logic [lps_pkg::KEY_W-1:0]      reply_id,
	output logic [lps_pkg::CNT_W-1:0]      rx_count,
	output logic                           table_full,
	output logic [lps_pkg::KEY_W-1:0]      id,
	output logic [lps_pkg::AGE_W-1:0]      lifetime,
	output lps_pkg::cell_cmd_t             cmd,
	output lps_pkg::token_t                tok_head,
	input  lps_pkg::token_t                tok_tail
);
	import lps_pkg::*;

	logic [VER_W-1:0] expver_q;
	logic [LEN_W-1:0] baselen_q;
	logic [AGE_W-1:0] lifetime_q;

	state_t           state_q, state_n;
	logic             launch_q;
	req_kind_t        kind_q;
	logic [VER_W-1:0] ver_q;
	logic [KEY_W-1:0] id_q;

	logic             done_q;
	reply_kind_t      reply_q;
	logic [VER_W-1:0] rver_q;
	logic [KEY_W-1:0] rid_q;
	logic [CNT_W-1:0] rx_q;
	logic             full_q;

	logic             accept;
	logic             serve;
	logic             finish;
	reply_kind_t      reply_n;
	logic [CNT_W-1:0] rx_n;
	logic             full_n;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign serve     = accept && (func == FUNC_PACKET) && (pkt_length >= MIN_PKT_LEN)
		&& (pkt_version == expver_q) && (pkt_length >= baselen_q);
	assign finish    = (state_q == ST_SEARCH) && tok_tail.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expver_q   <= EXPVER_RESET;
			baselen_q  <= BASELEN_RESET;
			lifetime_q <= LIFETIME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EXPVER:   expver_q   <= cfg_data[VER_W-1:0];
				CFG_BASELEN:  baselen_q  <= cfg_data[LEN_W-1:0];
				CFG_LIFETIME: lifetime_q <= cfg_data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_n;
			launch_q <= serve;
			done_q   <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (serve) begin
			kind_q <= req_kind_t'(request_kind);
			ver_q  <= pkt_version;
			id_q   <= session_id;
		end
		if (finish) begin
			reply_q <= reply_n;
			rver_q  <= ver_q;
			rid_q   <= id_q;
			rx_q    <= rx_n;
			full_q  <= full_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd.op  = CMD_NONE;
		cmd.idx = '0;
		reply_n = RPL_UNKNOWN;
		rx_n    = '0;
		full_n  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (serve) begin
					state_n = ST_SEARCH;
				end
				if (accept && (func == FUNC_TICK)) begin
					cmd.op = CMD_TICK;
				end
			end
			ST_SEARCH: begin
				if (tok_tail.vld) begin
					state_n = ST_IDLE;
					unique case (kind_q)
						REQ_INIT: begin
							reply_n = RPL_INITIATED;
							if (tok_tail.hit) begin
								cmd.op  = CMD_INIT;
								cmd.idx = tok_tail.hit_idx;
							end else if (tok_tail.free) begin
								cmd.op  = CMD_INIT;
								cmd.idx = tok_tail.free_idx;
							end else begin
								full_n = 1'b1;
							end
						end
						REQ_PING: begin
							if (tok_tail.hit) begin
								reply_n = RPL_PONG;
								rx_n    = tok_tail.cnt;
								cmd.op  = CMD_PING;
								cmd.idx = tok_tail.hit_idx;
							end else begin
								reply_n = RPL_PONG_WHO;
							end
						end
						REQ_CLEAN: begin
							reply_n = RPL_CLEANED;
							if (tok_tail.hit) begin
								cmd.op  = CMD_CLEAR;
								cmd.idx = tok_tail.hit_idx;
							end
						end
						default: reply_n = RPL_UNKNOWN;
					endcase
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		tok_head     = '0;
		tok_head.vld = launch_q;
	end

	assign id            = id_q;
	assign lifetime      = lifetime_q;
	assign done          = done_q;
	assign reply_kind    = reply_q;
	assign reply_version = rver_q;
	assign reply_id      = rid_q;
	assign rx_count      = rx_q;
	assign table_full    = full_q;

endmodule

[sv/loss_probe_session_table.sv]
// ----------------------------------------------------------------------------
// loss_probe_session_table
// Responder of a packet-loss probe with a chain of session entry cells.
// ----------------------------------------------------------------------------
// a served packet's lookup token walks one cell per cycle from a launch
// register through the cell registers to a registered reply strobe; busy
// holds off the next item until that strobe comes; ticks and dropped packets
// leave it low. the result is shown for one cycle, the receiver cannot stall it.
// reset clears all entry valid bits at once and loads the register defaults.
module loss_probe_session_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [lps_pkg::LEN_W-1:0]      pkt_length,
	input  logic [lps_pkg::VER_W-1:0]      pkt_version,
	input  logic [1:0]                     request_kind,
	input  logic [lps_pkg::KEY_W-1:0]      session_id,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           done,
	output logic [2:0]                     reply_kind,
	output logic [lps_pkg::VER_W-1:0]      reply_version,
	output logic [lps_pkg::KEY_W-1:0]      reply_id,
	output logic [lps_pkg::CNT_W-1:0]      rx_count,
	output logic                           table_full
);
	import lps_pkg::*;

	logic [KEY_W-1:0] id;
	logic [AGE_W-1:0] lifetime;
	cell_cmd_t        cmd;
	token_t           tok [0:TABLE_ENTRIES];

	lps_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.pkt_length    (pkt_length),
		.pkt_version   (pkt_version),
		.request_kind  (request_kind),
		.session_id    (session_id),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.reply_kind    (reply_kind),
		.reply_version (reply_version),
		.reply_id      (reply_id),
		.rx_count      (rx_count),
		.table_full    (table_full),
		.id            (id),
		.lifetime      (lifetime),
		.cmd           (cmd),
		.tok_head      (tok[0]),
		.tok_tail      (tok[TABLE_ENTRIES])
	);

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		lps_cell #(
			.CELL_IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.id       (id),
			.lifetime (lifetime),
			.cmd      (cmd),
			.tok_i    (tok[i]),
			.tok_o    (tok[i+1])
		);
	end

	// a reply only follows a token leaving the last cell
	a_done_after_tail: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(tok[TABLE_ENTRIES].vld))
		else $error("reply without a finished lookup");

	// a token in the tail means a search is open
	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok[TABLE_ENTRIES].vld |-> busy)
		else $error("lookup token outside a search");

	// aging only on an accepted tick
	a_tick_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_TICK) |-> (start && !busy && func == FUNC_TICK))
		else $error("aging without a tick transfer");

	// full flag only on an initiation reply
	a_full_init: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_full) |-> (reply_kind == RPL_INITIATED))
		else $error("table full flag on a non-initiation reply");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the loss probe session table: a scoreboard keeps
// its own copy of the session table and registers, predicts each reply from
// the accepted items, and checks every reply strobe against the oldest one.
// ----------------------------------------------------------------------------
module tb;
	import lps_pkg::*;

	localparam int ENTRIES = 64;
	localparam int CYCLE_LIMIT = 400000;
	// longest wait for a served packet plus margin
	localparam int SETTLE_CYCLES = ENTRIES + 8;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] ID_ONES = '1;

	typedef struct packed {
		logic             func;
		logic [LEN_W-1:0] len;
		logic [VER_W-1:0] ver;
		req_kind_t        kind;
		logic [KEY_W-1:0] id;
	} probe_item_t;

	typedef struct packed {
		reply_kind_t      kind;
		logic [VER_W-1:0] ver;
		logic [KEY_W-1:0] id;
		logic [CNT_W-1:0] rx;
		logic             full;
	} probe_reply_t;

	class probe_scoreboard #(int N = 64);
		logic [VER_W-1:0] want_version;
		logic [LEN_W-1:0] min_length;
		logic [AGE_W-1:0] lifetime;
		bit               live [N];
		logic [KEY_W-1:0] key [N];
		logic [CNT_W-1:0] pings [N];
		logic [AGE_W-1:0] idle [N];
		probe_reply_t     replies_due [$];
		int               errors;

		function new();
			want_version = EXPVER_RESET;
			min_length = BASELEN_RESET;
			lifetime = LIFETIME_RESET;
			errors = 0;
			foreach (live[i]) live[i] = 0;
		endfunction

		function void fail(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_EXPVER:   want_version = data[VER_W-1:0];
				CFG_BASELEN:  min_length = data[LEN_W-1:0];
				CFG_LIFETIME: lifetime = data[AGE_W-1:0];
				default: ;
			endcase
		endfunction

		// apply one accepted item to the table copy and queue its reply, if any
		function void note_item(probe_item_t it);
			int hit;
			int slot;
			probe_reply_t r;
			hit = -1;
			slot = -1;
			if (it.func == FUNC_TICK) begin
				for (int i = 0; i < N; i++) begin
					if (live[i]) begin
						if (idle[i] < AGE_MAX)
							idle[i]++;
						if (idle[i] >= lifetime)
							live[i] = 0;
					end
				end
				return;
			end
			if (it.len < MIN_PKT_LEN || it.ver != want_version || it.len < min_length)
				return;
			for (int i = N - 1; i >= 0; i--) begin
				if (live[i] && key[i] == it.id)
					hit = i;
				if (!live[i])
					slot = i;
			end
			r.kind = RPL_UNKNOWN;
			r.ver = it.ver;
			r.id = it.id;
			r.rx = '0;
			r.full = 1'b0;
			case (it.kind)
				REQ_INIT: begin
					r.kind = RPL_INITIATED;
					if (hit < 0)
						hit = slot;
					if (hit < 0) begin
						r.full = 1'b1;
					end else begin
						live[hit] = 1;
						key[hit] = it.id;
						pings[hit] = '0;
						idle[hit] = '0;
					end
				end
				REQ_PING: begin
					if (hit < 0) begin
						r.kind = RPL_PONG_WHO;
					end else begin
						r.kind = RPL_PONG;
						pings[hit] = pings[hit] + 1'b1;
						idle[hit] = '0;
						r.rx = pings[hit];
					end
				end
				REQ_CLEAN: begin
					r.kind = RPL_CLEANED;
					if (hit >= 0)
						live[hit] = 0;
				end
				default: r.kind = RPL_UNKNOWN;
			endcase
			replies_due.push_back(r);
		endfunction

		function void check_reply(probe_reply_t got);
			probe_reply_t want;
			if (replies_due.size() == 0) begin
				fail($sformatf("reply kind %0d id %h with no reply pending", got.kind, got.id));
				return;
			end
			want = replies_due.pop_front();
			if (got.kind !== want.kind || got.ver !== want.ver || got.id !== want.id ||
					got.rx !== want.rx || got.full !== want.full)
				fail($sformatf({"reply mismatch: exp kind %0d ver %h id %h rx %0d full %0b, ",
					"got kind %0d ver %h id %h rx %0d full %0b"},
					want.kind, want.ver, want.id, want.rx, want.full,
					got.kind, got.ver, got.id, got.rx, got.full));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  func;
	logic [LEN_W-1:0]      pkt_length;
	logic [VER_W-1:0]      pkt_version;
	logic [1:0]            request_kind;
	logic [KEY_W-1:0]      session_id;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  done;
	logic [2:0]            reply_kind;
	logic [VER_W-1:0]      reply_version;
	logic [KEY_W-1:0]      reply_id;
	logic [CNT_W-1:0]      rx_count;
	logic                  table_full;

	probe_scoreboard #(ENTRIES) sb;
	logic [KEY_W-1:0] id_pool [128];
	int cycles;

	loss_probe_session_table #(
		.TABLE_ENTRIES(ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.pkt_length(pkt_length),
		.pkt_version(pkt_version),
		.request_kind(request_kind),
		.session_id(session_id),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.reply_kind(reply_kind),
		.reply_version(reply_version),
		.reply_id(reply_id),
		.rx_count(rx_count),
		.table_full(table_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_reply('{reply_kind_t'(reply_kind), reply_version, reply_id,
				rx_count, table_full});
	end

	function automatic probe_item_t packet(int len, logic [VER_W-1:0] ver, req_kind_t kind,
			logic [KEY_W-1:0] id);
		return '{FUNC_PACKET, LEN_W'(len), ver, kind, id};
	endfunction

	function automatic probe_item_t tick();
		return '{FUNC_TICK, LEN_W'($urandom_range(1500)), VER_W'($urandom),
			req_kind_t'($urandom_range(3)), {$urandom, $urandom}};
	endfunction

	// one transfer on the command side, after a random gap
	task automatic send_item(probe_item_t it);
		int gap;
		gap = $urandom_range(5);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		func <= it.func;
		pkt_length <= it.len;
		pkt_version <= it.ver;
		request_kind <= it.kind;
		session_id <= it.id;
		do @(posedge clk); while (busy);
		sb.note_item(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		start <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait out pending replies and any lookup still walking the table
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [VER_W-1:0] ver, int base, int life, int n, int tick_pct,
			int init_pct, int pool_n);
		probe_item_t it;
		int r;
		drain();
		write_reg(CFG_EXPVER, ver);
		write_reg(CFG_BASELEN, CFG_DATA_W'(base));
		write_reg(CFG_LIFETIME, CFG_DATA_W'(life));
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < tick_pct) begin
				it = tick();
			end else if ($urandom_range(99) < 85) begin
				it = packet($urandom_range(1500, base), ver, REQ_OTHER,
					id_pool[$urandom_range(pool_n - 1)]);
				r = $urandom_range(99);
				if (r < init_pct)
					it.kind = REQ_INIT;
				else if (r < init_pct + (100 - init_pct) * 6 / 10)
					it.kind = REQ_PING;
				else if (r < 95)
					it.kind = REQ_CLEAN;
				if ($urandom_range(9) == 0)
					it.id = {$urandom, $urandom};
			end else begin
				// malformed or off-version packets
				it = packet($urandom_range(1500, base), ver, req_kind_t'($urandom_range(3)),
					id_pool[$urandom_range(pool_n - 1)]);
				case ($urandom_range(3))
					0: it.len = LEN_W'($urandom_range(1));
					1: it.len = LEN_W'($urandom_range(base - 1));
					2: it.ver = ver ^ (VER_W'(1) << $urandom_range(VER_W - 1));
					default: it = packet($urandom_range(1500), VER_W'($urandom),
						req_kind_t'($urandom_range(3)), {$urandom, $urandom});
				endcase
			end
			send_item(it);
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FUNC_PACKET;
		pkt_length <= '0;
		pkt_version <= '0;
		request_kind <= REQ_INIT;
		session_id <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_EXPVER;
		cfg_data <= '0;
		id_pool[0] = '0;
		id_pool[1] = ID_ONES;
		id_pool[2] = 64'h1;
		id_pool[3] = 64'h8000_0000_0000_0000;
		for (int i = 4; i < 128; i++)
			id_pool[i] = {$urandom, $urandom};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// register defaults: version 0, base length 16, lifetime 60
		send_item(packet(0, 16'h0, REQ_INIT, 64'h5));
		send_item(packet(1, 16'h0, REQ_INIT, 64'h5));
		send_item(packet(15, 16'h0, REQ_INIT, 64'h5));
		send_item(packet(16, 16'h1, REQ_INIT, 64'h5));
		send_item(packet(16, 16'h0, REQ_INIT, '0));
		send_item(packet(1500, 16'h0, REQ_INIT, ID_ONES));
		send_item(packet(16, 16'h0, REQ_PING, '0));
		send_item(packet(40, 16'h0, REQ_PING, '0));
		send_item(packet(16, 16'h0, REQ_PING, 64'h1));
		send_item(packet(16, 16'h0, REQ_INIT, '0));
		send_item(packet(16, 16'h0, REQ_PING, '0));
		send_item(packet(16, 16'h0, REQ_CLEAN, '0));
		send_item(packet(16, 16'h0, REQ_CLEAN, '0));
		send_item(packet(16, 16'h0, REQ_PING, '0));
		send_item(packet(16, 16'h0, REQ_OTHER, ID_ONES));
		send_item(tick());
		send_item(packet(16, 16'h0, REQ_INIT, '0));
		drain();
		// zero lifetime, ignored register index, base length with stray high bits
		write_reg(CFG_LIFETIME, 16'h0);
		write_reg(CFG_UNUSED, 16'hFFFF);
		write_reg(CFG_BASELEN, 16'hF812);
		send_item(tick());
		send_item(packet(16, 16'h0, REQ_PING, ID_ONES));
		send_item(packet(17, 16'h0, REQ_PING, '0));
		send_item(packet(18, 16'h0, REQ_PING, '0));

		run_phase(16'hFFFF, 2, 1, 60, 20, 40, 16);
		run_phase(VER_W'($urandom), 1500, 127, 130, 2, 70, 100);
		run_phase(VER_W'($urandom), $urandom_range(1500, 2), $urandom_range(127, 1), 110,
			15, 30, 40);
		run_phase(VER_W'($urandom), 2, 3, 100, 25, 30, 24);
		run_phase(EXPVER_RESET, BASELEN_RESET, LIFETIME_RESET, 100, 10, 30, 70);
		drain();

		if (sb.replies_due.size() != 0)
			sb.fail("replies still pending at end of run");
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
